[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL. Simulation builds get concurrent
// assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication or plain property checked at every rising clock edge out of reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true at a rising clock edge out of reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

[hw/rtl/smpq_pkg.sv]
`default_nettype none

package smpq_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        [1:0]  operation;
    logic signed [31:0] item_value;
    logic signed [15:0] priority_req;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic signed [15:0] out_priority;
    logic        [1:0]  status;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic signed [15:0] prio;
    logic signed [31:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

[hw/rtl/smpq_ram.sv]
`default_nettype none

module smpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/sorted_min_priority_queue.sv]
// Sorted minimum priority queue of up to CAPACITY (value, priority) entries.
// Requests arrive on req (req_valid/req_ready); results leave on rsp
// (rsp_valid/rsp_ready). Operation insert adds an entry behind all entries
// of lower or equal priority, delete removes and returns the minimum, and
// list returns every entry in ascending order with last set on the final one.
// Entries live in one memory with a single registered read port; a small
// sequencer walks it one entry at a time, reading an entry in one cycle and
// comparing, writing back or emitting it in the next.
// While busy, an insert moves each larger entry up one place, a delete
// returns the minimum and shifts the remaining entries down, and a list
// reads out every entry; an empty or full request answers with a status
// only. req_ready is low while a request is being worked on.
// Results go through an output register, so a delete emits its result first
// and then shifts the remaining entries while that result waits. When the
// receiver stalls, the sequencer waits at its next result and holds its place.
// Reset empties the queue at once; memory contents are not cleared and are
// never read before they are written. Operation code 3 is dropped silently.
`default_nettype none

`include "assert_macros.svh"

module sorted_min_priority_queue
  import smpq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_OUT,
    S_DEL_SRD,
    S_DEL_SWR,
    S_LST_RD,
    S_LST_OUT,
    S_RESP
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  count, count_next;
  entry_t            new_ent, new_ent_next;
  logic [1:0]        resp_st, resp_st_next;
  logic              rsp_valid_next;
  rsp_t              rsp_next;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  entry_t            wdata;
  logic [ENTRY_W-1:0] rdata;
  entry_t            rd_ent;

  logic [CNT_W-1:0]  idx_dec;
  logic [CNT_W-1:0]  idx_inc;
  logic              slot_free;

  assign rd_ent    = entry_t'(rdata);
  assign idx_dec   = idx - CNT_W'(1);
  assign idx_inc   = idx + CNT_W'(1);
  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  smpq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    count_next     = count;
    new_ent_next   = new_ent;
    resp_st_next   = resp_st;
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_next       = rsp;
    we             = 1'b0;
    waddr          = idx[ADDR_W-1:0];
    wdata          = new_ent;
    raddr          = idx[ADDR_W-1:0];

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req.operation)
            OP_INSERT: begin
              if (count == CAP_CNT) begin
                resp_st_next = ST_FULL;
                state_next   = S_RESP;
              end else begin
                new_ent_next.prio  = req.priority_req;
                new_ent_next.value = req.item_value;
                idx_next           = count;
                state_next         = (count == '0) ? S_INS_PUT : S_INS_RD;
              end
            end
            OP_DELETE: begin
              if (count == '0) begin
                resp_st_next = ST_EMPTY;
                state_next   = S_RESP;
              end else begin
                state_next = S_DEL_RD;
              end
            end
            OP_LIST: begin
              if (count == '0) begin
                resp_st_next = ST_EMPTY;
                state_next   = S_RESP;
              end else begin
                idx_next   = '0;
                state_next = S_LST_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_INS_RD: begin
        raddr      = idx_dec[ADDR_W-1:0];
        state_next = S_INS_CMP;
      end

      // The entry just below the hole is compared with the new key: equal
      // keys stay ahead of the new entry, larger ones move up one place.
      S_INS_CMP: begin
        raddr = idx_dec[ADDR_W-1:0];
        we    = 1'b1;
        if ($signed(rd_ent.prio) <= $signed(new_ent.prio)) begin
          wdata        = new_ent;
          count_next   = count + CNT_W'(1);
          resp_st_next = ST_OK;
          state_next   = S_RESP;
        end else begin
          wdata      = rd_ent;
          idx_next   = idx_dec;
          state_next = (idx_dec == '0) ? S_INS_PUT : S_INS_RD;
        end
      end

      S_INS_PUT: begin
        we           = 1'b1;
        wdata        = new_ent;
        count_next   = count + CNT_W'(1);
        resp_st_next = ST_OK;
        state_next   = S_RESP;
      end

      S_DEL_RD: begin
        raddr      = '0;
        state_next = S_DEL_OUT;
      end

      S_DEL_OUT: begin
        raddr = '0;
        if (slot_free) begin
          rsp_valid_next        = 1'b1;
          rsp_next.out_value    = rd_ent.value;
          rsp_next.out_priority = rd_ent.prio;
          rsp_next.status       = ST_OK;
          rsp_next.last         = 1'b1;
          if (count == CNT_W'(1)) begin
            count_next = '0;
            state_next = S_IDLE;
          end else begin
            idx_next   = CNT_W'(1);
            state_next = S_DEL_SRD;
          end
        end
      end

      S_DEL_SRD: begin
        state_next = S_DEL_SWR;
      end

      S_DEL_SWR: begin
        we    = 1'b1;
        waddr = idx_dec[ADDR_W-1:0];
        wdata = rd_ent;
        if (idx_inc == count) begin
          count_next = count - CNT_W'(1);
          state_next = S_IDLE;
        end else begin
          idx_next   = idx_inc;
          state_next = S_DEL_SRD;
        end
      end

      S_LST_RD: begin
        state_next = S_LST_OUT;
      end

      S_LST_OUT: begin
        if (slot_free) begin
          rsp_valid_next        = 1'b1;
          rsp_next.out_value    = rd_ent.value;
          rsp_next.out_priority = rd_ent.prio;
          rsp_next.status       = ST_OK;
          rsp_next.last         = (idx_inc == count);
          if (idx_inc == count) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx_inc;
            state_next = S_LST_RD;
          end
        end
      end

      S_RESP: begin
        if (slot_free) begin
          rsp_valid_next        = 1'b1;
          rsp_next.out_value    = '0;
          rsp_next.out_priority = '0;
          rsp_next.status       = resp_st;
          rsp_next.last         = 1'b1;
          state_next            = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
    idx     <= idx_next;
    new_ent <= new_ent_next;
    resp_st <= resp_st_next;
    rsp     <= rsp_next;
  end

  `ASSERT_NEVER(a_count_bound, clk, rst, count > CAP_CNT, "entry count above capacity")

  `ASSERT_CLK(a_empty_delete, clk, rst,
    (req_valid && req_ready && req.operation == OP_DELETE && count == '0) |=> state == S_RESP,
    "delete on empty queue must answer with a status only")

  `ASSERT_CLK(a_not_last_ok, clk, rst,
    (rsp_valid && !rsp.last) |-> (rsp.status == ST_OK && state != S_IDLE),
    "only a list result in progress may leave last low")

endmodule

`default_nettype wire

[test/sorted_min_priority_queue_tb.sv]
`timescale 1ns / 100ps

module sorted_min_priority_queue_tb;
  import smpq_pkg::*;

  // Operation code 3 is not defined in the package; the block drops such requests.
  localparam logic [1:0] OP_IGNORED = 2'd3;

  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_AT_RESULT = 150;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_PRINTED = 50;

  typedef struct {
    req_t        req;
    int unsigned gap;
    bit          sync_point;
  } pending_req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } queued_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  pending_req_t  pending_reqs[$];
  queued_entry_t held_entries[$];
  rsp_t          expected_rsp[$];

  pending_req_t cur_req;
  int unsigned  tx_gap_left;
  bit           tx_calm;
  bit           results_drained;

  int unsigned rx_wait_left;
  int unsigned hold_left;
  int unsigned rx_count;
  int unsigned next_wait;
  int unsigned error_count;
  bit          rx_calm;
  rsp_t        want;

  sorted_min_priority_queue dut (
    .clk,
    .rst,
    .req_valid,
    .req_ready,
    .req,
    .rsp_valid,
    .rsp_ready,
    .rsp
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, exp_val);
  endtask

  // Updates the sorted entry list for one request and queues the results it causes.
  function automatic void apply_request(req_t r);
    queued_entry_t e;
    rsp_t          res;
    int            pos;
    res = '0;
    res.last = 1'b1;
    case (r.operation)
      OP_INSERT: begin
        if (held_entries.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_entries.size() &&
                 $signed(held_entries[pos].prio) <= $signed(r.priority_req))
            pos++;
          e.value = r.item_value;
          e.prio = r.priority_req;
          held_entries.insert(pos, e);
          res.status = ST_OK;
        end
        expected_rsp.push_back(res);
      end
      OP_DELETE: begin
        if (held_entries.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          e = held_entries.pop_front();
          res.out_value = e.value;
          res.out_priority = e.prio;
          res.status = ST_OK;
        end
        expected_rsp.push_back(res);
      end
      OP_LIST: begin
        if (held_entries.size() == 0) begin
          res.status = ST_EMPTY;
          expected_rsp.push_back(res);
        end else begin
          foreach (held_entries[k]) begin
            res.out_value = held_entries[k].value;
            res.out_priority = held_entries[k].prio;
            res.status = ST_OK;
            res.last = (k == held_entries.size() - 1);
            expected_rsp.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic queue_request(logic [1:0] op, logic [31:0] value, logic [15:0] prio);
    pending_req_t p;
    p.req.operation = op;
    p.req.item_value = value;
    p.req.priority_req = prio;
    p.gap = tx_calm ? 0 : $urandom_range(7);
    p.sync_point = 1'b0;
    pending_reqs.push_back(p);
  endtask

  // Request driver. A sync point holds the sender until every result is back.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
      tx_gap_left <= 0;
    end else if (!req_valid || req_ready) begin
      if (tx_gap_left != 0) begin
        tx_gap_left <= tx_gap_left - 1;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        req_valid <= 1'b0;
      end else if (pending_reqs[0].sync_point) begin
        req_valid <= 1'b0;
        if (!req_valid && results_drained)
          void'(pending_reqs.pop_front());
      end else begin
        cur_req = pending_reqs.pop_front();
        req <= cur_req.req;
        req_valid <= 1'b1;
        tx_gap_left <= cur_req.gap;
      end
    end
  end

  // Result receiver, with random stalls, calm stretches and one long hold-off.
  assign rx_calm = ((rx_count / 50) % 3) == 2;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rx_wait_left <= 0;
      hold_left <= 0;
      rx_count <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= (hold_left == 1);
    end else if (rsp_valid && rsp_ready) begin
      rx_count <= rx_count + 1;
      if (rx_count == HOLD_AT_RESULT) begin
        hold_left <= HOLD_CYCLES;
        rsp_ready <= 1'b0;
      end else begin
        next_wait = rx_calm ? 0 : $urandom_range(7);
        rx_wait_left <= next_wait;
        rsp_ready <= (next_wait == 0);
      end
    end else if (rx_wait_left != 0) begin
      rx_wait_left <= rx_wait_left - 1;
      rsp_ready <= (rx_wait_left == 1);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Monitor: results are checked before a request accepted at the same edge is applied.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected result, value", rsp.out_value, '0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.out_value !== want.out_value)
            report_mismatch("out_value", rsp.out_value, want.out_value);
          if (rsp.out_priority !== want.out_priority)
            report_mismatch("out_priority", 32'(rsp.out_priority), 32'(want.out_priority));
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.last !== want.last)
            report_mismatch("last", 32'(rsp.last), 32'(want.last));
        end
      end
      if (req_valid && req_ready)
        apply_request(req);
      results_drained <= (expected_rsp.size() == 0);
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL sorted_min_priority_queue");
    $finish;
  end

  initial begin
    int          ins_pct;
    int          roll;
    logic [15:0] prio;
    pending_req_t sync_req;

    error_count = 0;
    results_drained = 1'b1;
    tx_calm = 1'b0;

    // Directed part: empty cases, ignored code, field extremes, ties, full queue.
    queue_request(OP_LIST, 32'h1234_5678, 16'h0011);
    queue_request(OP_DELETE, 32'hffff_ffff, 16'hffff);
    queue_request(OP_IGNORED, 32'hdead_beef, 16'h5555);
    queue_request(OP_INSERT, 32'h7fff_ffff, 16'h7fff);
    queue_request(OP_INSERT, 32'h8000_0000, 16'h8000);
    queue_request(OP_INSERT, 32'h0000_0000, 16'h0000);
    queue_request(OP_INSERT, 32'hffff_ffff, 16'hffff);
    // Equal priority goes behind the earlier entry.
    queue_request(OP_INSERT, 32'h0000_0001, 16'h0000);
    queue_request(OP_LIST, 32'haaaa_aaaa, 16'haaaa);
    queue_request(OP_DELETE, 32'h5555_5555, 16'h5555);
    for (int i = 0; i < CAPACITY - 4; i++)
      queue_request(OP_INSERT, $urandom, 16'($signed($urandom_range(6)) - 3));
    queue_request(OP_INSERT, 32'h5a5a_5a5a, 16'h8000);
    queue_request(OP_LIST, 32'h0, 16'h0);
    queue_request(OP_DELETE, 32'h0, 16'h0);

    ins_pct = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: ins_pct = 70;
          1: ins_pct = 45;
          default: ins_pct = 25;
        endcase
        tx_calm = ($urandom_range(3) == 0);
      end
      if (i == 150 || i == 320) begin
        sync_req.req = '0;
        sync_req.gap = 0;
        sync_req.sync_point = 1'b1;
        pending_reqs.push_back(sync_req);
      end
      case ($urandom_range(3))
        0: prio = 16'($signed($urandom_range(8)) - 4);
        1: begin
          case ($urandom_range(3))
            0: prio = 16'h8000;
            1: prio = 16'h7fff;
            2: prio = 16'h8001;
            default: prio = 16'h7ffe;
          endcase
        end
        default: prio = 16'($urandom);
      endcase
      roll = $urandom_range(99);
      if (roll < ins_pct)
        queue_request(OP_INSERT, $urandom, prio);
      else if (roll < ins_pct + 10)
        queue_request(OP_LIST, $urandom, prio);
      else if (roll < ins_pct + 13)
        queue_request(OP_IGNORED, $urandom, prio);
      else
        queue_request(OP_DELETE, $urandom, prio);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    do
      @(posedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_rsp.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("PASS sorted_min_priority_queue");
    else
      $display("FAIL sorted_min_priority_queue");
    $finish;
  end

endmodule

[sorted_min_priority_queue.f]
+incdir+hw/rtl
hw/rtl/smpq_pkg.sv
hw/rtl/smpq_ram.sv
hw/rtl/sorted_min_priority_queue.sv
test/sorted_min_priority_queue_tb.sv
